// ===== hw/rtl/pnc_pkg.sv =====
// shared types and constants for the perfect number counter
// no dependencies
`default_nettype none

package pnc_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned N_W       = 31;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned SUM_W     = 34;
  localparam int unsigned SIGMA_W   = 35;
  localparam int unsigned COUNT_W   = 8;
  localparam logic [COUNT_W-1:0] COUNT_FIELD_MAX = 8'd255;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_of_list;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0]   aliquot_sum;
    logic               is_perfect;
    logic [COUNT_W-1:0] perfect_count;
    logic               list_done;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [VALUE_W-1:0]   dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [VALUE_W-1:0]   quotient;
    logic [DIVISOR_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pnc_divider.sv =====
// restoring divider, one quotient bit per cycle, 32-bit by 16-bit
// depends on pnc_pkg
`default_nettype none

module pnc_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pnc_pkg::div_req_t req,
  output pnc_pkg::div_rsp_t      rsp
);
  import pnc_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_W);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [VALUE_W-1:0]   quo;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  assign shifted = {rem, quo[VALUE_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DIVISOR_W-1:0];
        quo <= {quo[VALUE_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVISOR_W-1:0];
        quo <= {quo[VALUE_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy && divisor != '0 |-> rem < divisor)
    else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/perfect_number_counter_core.sv =====
// a value of zero or below goes straight to the finish state; for a positive value n the divider
//   runs once per trial divisor d = 1, 2, ... until the quotient drops below d; one transaction
//   at a time, the next item is not taken until the result of the last one has been loaded
// rst is synchronous active high; it clears the sequencer, the output valid and
//   the per-list count
`default_nettype none

module perfect_number_counter_core #(
  parameter int unsigned MAX_LIST = 128
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire pnc_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output pnc_pkg::result_t      result
);
  import pnc_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
    (MAX_LIST > 255) ? COUNT_FIELD_MAX : COUNT_W'(MAX_LIST);

  state_t               state;
  state_t               state_next;
  logic [N_W-1:0]       n;
  logic [DIVISOR_W-1:0] d;
  logic [SIGMA_W-1:0]   sigma;
  logic                 last;
  logic [COUNT_W-1:0]   count;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 accept;
  logic                 load_out;
  logic                 positive;
  logic                 q_below;
  logic [VALUE_W:0]     term;
  logic [SIGMA_W-1:0]   diff;
  logic                 perfect;
  logic [COUNT_W-1:0]   count_new;

  pnc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign positive = !item.value[VALUE_W-1] && (item.value != '0);
  assign q_below  = div_rsp.quotient < VALUE_W'(d);
  assign term     = (div_rsp.quotient == VALUE_W'(d)) ? (VALUE_W+1)'(d)
                  : (VALUE_W+1)'(div_rsp.quotient) + (VALUE_W+1)'(d);
  assign diff     = sigma - SIGMA_W'(n);
  assign perfect  = (n != '0) && (diff[SUM_W-1:0] == SUM_W'(n));
  assign count_new = (perfect && count < COUNT_LIMIT) ? count + COUNT_W'(1) : count;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = positive ? ST_ISSUE : ST_FINISH;
        end
      end
      ST_ISSUE: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_next = q_below ? ST_FINISH : ST_ISSUE;
        end
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready       = 1'b0;
    div_req.start    = 1'b0;
    load_out         = 1'b0;
    div_req.dividend = VALUE_W'(n);
    div_req.divisor  = d;
    unique case (state)
      ST_IDLE:   item_ready = 1'b1;
      ST_ISSUE:  div_req.start = 1'b1;
      ST_WAIT:   ;
      ST_FINISH: load_out = !result_valid || result_ready;
      default:   ;
    endcase
  end

  assign accept = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      count        <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        result_valid <= 1'b1;
        count        <= last ? '0 : count_new;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n     <= positive ? item.value[N_W-1:0] : '0;
      d     <= DIVISOR_W'(1);
      sigma <= '0;
      last  <= item.last_of_list;
    end else if (state == ST_WAIT && div_rsp.done && !q_below) begin
      d <= d + DIVISOR_W'(1);
      if (div_rsp.remainder == '0) begin
        sigma <= sigma + SIGMA_W'(term);
      end
    end
    if (load_out) begin
      result.aliquot_sum   <= diff[SUM_W-1:0];
      result.is_perfect    <= perfect;
      result.perfect_count <= count_new;
      result.list_done     <= last;
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_WAIT)
    else $error("divider result outside wait state");
  a_sigma_covers_n: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> sigma >= SIGMA_W'(n))
    else $error("divisor sum below value");
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_ISSUE |-> d != '0)
    else $error("trial divisor is zero");
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.perfect_count <= COUNT_LIMIT)
    else $error("count above limit");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_perfect_number_counter_core.sv =====
// self-checking testbench for perfect_number_counter_core: random and directed lists,
// predicted aliquot sums and per-list perfect counts checked against every result
// depends on pnc_pkg and perfect_number_counter_core
`default_nettype none

module tb_perfect_number_counter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pnc_pkg::*;

  localparam int unsigned MAX_LIST       = 128;
  localparam int unsigned RANDOM_ITEMS   = 430;
  localparam int unsigned SATURATION_LEN = 140;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned WATCHDOG_LIMIT = 8_000_000;
  localparam int unsigned DIRECTED_N     = 18;

  class list_tally_model;
    int unsigned running_count;
    int unsigned count_cap;
    int unsigned failures;
    result_t     pending_results[$];

    function new(int unsigned max_list);
      running_count = 0;
      failures      = 0;
      count_cap     = (max_list > 32'(COUNT_FIELD_MAX)) ? 32'(COUNT_FIELD_MAX) : max_list;
    endfunction

    function logic [SUM_W-1:0] aliquot_of(logic signed [VALUE_W-1:0] v);
      longint unsigned n;
      longint unsigned d;
      longint unsigned total;
      total = 0;
      if (v <= 0) return '0;
      n = {32'b0, v};
      for (d = 1; d * d <= n; d++) begin
        if (n % d == 0) begin
          total += d;
          if (n / d != d) total += n / d;
        end
      end
      return SUM_W'(total - n);
    endfunction

    function void note_item(item_t it);
      result_t want;
      want.aliquot_sum = aliquot_of(it.value);
      want.is_perfect  = (it.value > 0) && (want.aliquot_sum == {2'b00, it.value});
      if (want.is_perfect && running_count < count_cap) running_count++;
      want.perfect_count = COUNT_W'(running_count);
      want.list_done     = it.last_of_list;
      if (it.last_of_list) running_count = 0;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t ns: unexpected result, actual sum %0d perfect %0d count %0d done %0d",
                 $time, got.aliquot_sum, got.is_perfect, got.perfect_count, got.list_done);
        return;
      end
      want = pending_results.pop_front();
      compare_field("aliquot_sum", 64'(want.aliquot_sum), 64'(got.aliquot_sum));
      compare_field("is_perfect", 64'(want.is_perfect), 64'(got.is_perfect));
      compare_field("perfect_count", 64'(want.perfect_count), 64'(got.perfect_count));
      compare_field("list_done", 64'(want.list_done), 64'(got.list_done));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  bit          steady_phase = 1'b0;
  int unsigned quiet_cycles = 0;

  list_tally_model tally = new(MAX_LIST);

  int directed_values [DIRECTED_N] = '{
    0, 1, 2, 3, 6, 28, -1, -2147483648, 2147483647,
    12, 945, 97, 496, 8128, 6, 0, -6, 4
  };
  bit directed_last [DIRECTED_N] = '{
    0, 0, 0, 0, 0, 1, 0, 0, 0,
    0, 0, 0, 0, 1, 1, 1, 0, 1
  };

  perfect_number_counter_core #(
    .MAX_LIST(MAX_LIST)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    result_ready <= steady_phase || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) tally.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("perfect_number_counter_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_perfect();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 6;
    if (roll < 6) return 28;
    if (roll < 9) return 496;
    return 8128;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return pick_perfect();
    if (roll < 55) return $urandom_range(1, 1000);
    if (roll < 72) return {1'b1, 31'($urandom)};
    if (roll < 77) return $urandom_range(0, 1);
    if (roll < 82) return $urandom_range(1, 65535);
    return 2 * $urandom_range(1, 200);
  endfunction

  task automatic send_item(item_t it);
    @(negedge clk);
    if (!steady_phase && $urandom_range(0, 99) < 20) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    item       = it;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    tally.note_item(it);
  endtask

  initial begin
    item_t       it;
    int unsigned sent;
    int unsigned list_len;
    bit          saturation_done;
    sent            = 0;
    saturation_done = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    foreach (directed_values[i]) begin
      it.value        = directed_values[i];
      it.last_of_list = directed_last[i];
      send_item(it);
    end

    while (sent < RANDOM_ITEMS) begin
      if (!saturation_done && sent >= 120) begin
        // long list, mostly perfect numbers, that can drive the count into saturation, no idling on either side
        steady_phase = 1'b1;
        for (int k = 0; k < SATURATION_LEN; k++) begin
          it.value        = ($urandom_range(0, 9) < 9) ? pick_perfect() : pick_value();
          it.last_of_list = (k == SATURATION_LEN - 1);
          send_item(it);
        end
        steady_phase    = 1'b0;
        saturation_done = 1'b1;
        sent += SATURATION_LEN;
      end else begin
        list_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 8);
        for (int k = 0; k < list_len; k++) begin
          it.value        = pick_value();
          it.last_of_list = (k == list_len - 1);
          send_item(it);
        end
        sent += list_len;
      end
    end

    @(negedge clk);
    item_valid = 1'b0;
    while (tally.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tally.failures == 0) begin
      $display("perfect_number_counter_core regression: pass");
    end else begin
      $display("perfect_number_counter_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
